[rtl/core/wlpc_pkg.sv]
// shared types, constants and helpers for the waypoint list block
// no dependencies

package wlpc_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int GROUP_COUNT = 3;
  localparam int DEPTH       = GROUP_COUNT * MAX_POINTS;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int GRP_W       = 2;
  localparam int ANGLE_W     = 16;
  localparam int STEPS_W     = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;

  localparam logic [GRP_W-1:0] REG_ACTIVE_GROUP = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_DEL   = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // one waypoint, servo 1 in the lowest bits
  typedef struct packed {
    logic signed [STEPS_W-1:0] steps;
    logic [ANGLE_W-1:0]        angle_five;
    logic [ANGLE_W-1:0]        angle_four;
    logic [ANGLE_W-1:0]        angle_three;
    logic [ANGLE_W-1:0]        angle_two;
    logic [ANGLE_W-1:0]        angle_one;
  } wp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    wp_t               wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    entry_count;
    logic [IDX_W-1:0]    play_cursor;
    logic                playing;
    wp_t                 data;
  } res_t;

  function automatic logic [ADDR_W-1:0] wp_addr(logic [GRP_W-1:0] g, logic [IDX_W-1:0] i);
    return ADDR_W'(g) * ADDR_W'(MAX_POINTS) + ADDR_W'(i);
  endfunction

endpackage

[rtl/core/wlpc_store.sv]
// waypoint memory for all three lists, one write and one registered read port
// depends on wlpc_pkg

module wlpc_store (
  input  logic               clk,
  input  wlpc_pkg::mem_req_t req,
  output wlpc_pkg::wp_t      rd_q
);

  wlpc_pkg::wp_t mem [wlpc_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

endmodule

[rtl/core/wlpc_seq.sv]
// command sequencer: list lengths, play cursor, and the entry shift loop
// depends on wlpc_pkg, drives wlpc_store through a request struct

module wlpc_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wlpc_pkg::CMD_W-1:0] cmd,
  input  wlpc_pkg::wp_t              wp_in,
  input  logic [wlpc_pkg::IDX_W-1:0] point_index,
  input  logic [wlpc_pkg::GRP_W-1:0] group,
  input  logic                       res_take,
  input  wlpc_pkg::wp_t              rd_q,
  output logic                       idle,
  output wlpc_pkg::mem_req_t         req,
  output wlpc_pkg::res_t             res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_RDWAIT,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic [wlpc_pkg::CNT_W-1:0]   len_r [wlpc_pkg::GROUP_COUNT];
  logic [wlpc_pkg::IDX_W-1:0]   cursor_r;
  logic                         playing_r;
  logic [wlpc_pkg::CMD_W-1:0]   cmd_r;
  wlpc_pkg::wp_t                wp_r;
  logic [wlpc_pkg::IDX_W-1:0]   idx_r;
  logic [wlpc_pkg::GRP_W-1:0]   grp_r;
  logic [wlpc_pkg::STATUS_W-1:0] status_r;
  wlpc_pkg::wp_t                data_r;
  logic [wlpc_pkg::CNT_W-1:0]   ptr_r;
  logic [wlpc_pkg::IDX_W-1:0]   wr_idx_r;
  logic                         pend_r;

  logic [wlpc_pkg::CNT_W-1:0]   len_cur;
  logic [wlpc_pkg::CNT_W-1:0]   len_dec;
  logic [wlpc_pkg::IDX_W-1:0]   cur_adj;
  logic                         empty;
  logic                         out_of_range;
  logic                         ptr_live;

  assign len_cur      = len_r[grp_r];
  assign len_dec      = len_cur - wlpc_pkg::CNT_W'(1);
  assign empty        = (len_cur == '0);
  assign out_of_range = ({1'b0, idx_r} >= len_cur);
  assign ptr_live     = (ptr_r < len_cur);
  // cursor steps back past a removed entry only while playing
  assign cur_adj      = (playing_r && (cursor_r > idx_r)) ?
                        cursor_r - wlpc_pkg::IDX_W'(1) : cursor_r;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    req.we    = 1'b0;
    req.waddr = wlpc_pkg::wp_addr(grp_r, len_cur[wlpc_pkg::IDX_W-1:0]);
    req.wdata = wp_r;
    req.raddr = wlpc_pkg::wp_addr(grp_r, idx_r);
    if (state_r == S_EXEC && cmd_r == wlpc_pkg::CMD_ADD &&
        len_cur < wlpc_pkg::CNT_W'(wlpc_pkg::MAX_POINTS)) begin
      req.we = 1'b1;
    end
    if (state_r == S_SHIFT) begin
      req.raddr = wlpc_pkg::wp_addr(grp_r, ptr_r[wlpc_pkg::IDX_W-1:0]);
      req.we    = pend_r;
      req.waddr = wlpc_pkg::wp_addr(grp_r, wr_idx_r);
      req.wdata = rd_q;
    end
  end

  always_comb begin
    res.valid       = (state_r == S_DONE);
    res.status      = status_r;
    res.entry_count = len_cur;
    res.play_cursor = cursor_r;
    res.playing     = playing_r;
    res.data        = data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cursor_r  <= '0;
      playing_r <= 1'b0;
      pend_r    <= 1'b0;
      for (int g = 0; g < wlpc_pkg::GROUP_COUNT; g++) begin
        len_r[g] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd;
            wp_r     <= wp_in;
            idx_r    <= point_index;
            grp_r    <= group;
            status_r <= wlpc_pkg::ST_OK;
            data_r   <= '0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
          unique case (cmd_r)
            wlpc_pkg::CMD_ADD: begin
              if (len_cur >= wlpc_pkg::CNT_W'(wlpc_pkg::MAX_POINTS)) begin
                status_r <= wlpc_pkg::ST_FULL;
              end else begin
                len_r[grp_r] <= len_cur + wlpc_pkg::CNT_W'(1);
              end
            end
            wlpc_pkg::CMD_DEL: begin
              if (empty) begin
                status_r <= wlpc_pkg::ST_EMPTY;
              end else if (out_of_range) begin
                status_r <= wlpc_pkg::ST_RANGE;
              end else begin
                ptr_r   <= {1'b0, idx_r} + wlpc_pkg::CNT_W'(1);
                pend_r  <= 1'b0;
                state_r <= S_SHIFT;
              end
            end
            wlpc_pkg::CMD_START: begin
              if (empty) begin
                status_r <= wlpc_pkg::ST_EMPTY;
              end else begin
                cursor_r  <= '0;
                playing_r <= 1'b1;
              end
            end
            wlpc_pkg::CMD_STOP: begin
              playing_r <= 1'b0;
            end
            wlpc_pkg::CMD_READ: begin
              if (empty) begin
                status_r <= wlpc_pkg::ST_EMPTY;
              end else if (out_of_range) begin
                status_r <= wlpc_pkg::ST_RANGE;
              end else begin
                state_r <= S_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
        S_SHIFT: begin
          // read entry ptr, write it one slot down in the following cycle
          if (ptr_live) begin
            ptr_r    <= ptr_r + wlpc_pkg::CNT_W'(1);
            wr_idx_r <= ptr_r[wlpc_pkg::IDX_W-1:0] - wlpc_pkg::IDX_W'(1);
            pend_r   <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              len_r[grp_r] <= len_dec;
              cursor_r     <= ({1'b0, cur_adj} >= len_dec) ? '0 : cur_adj;
              state_r      <= S_DONE;
            end
          end
        end
        S_RDWAIT: begin
          data_r  <= rd_q;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/waypoint_list_with_play_cursor.sv]
// top level: stream channels, register port, output register; uses wlpc_seq, wlpc_store
// delete runs a shift loop that moves each later entry one slot down, one entry per cycle;
// one command in flight, the next input transfer is taken once the result has moved into
// the output register; reset (synchronous, active low) empties all lists, clears cursor,
// play flag, active group and output valid, keeps memory

module waypoint_list_with_play_cursor (
  input  logic         clk,
  input  logic         rst_n,
  // command stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd, angle_one, angle_two, angle_three, angle_four, angle_five,
  // step_count, point_index, zero fill
  input  logic [127:0] in_tdata,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, entry_count, play_cursor, playing, out_angle_one, out_angle_two,
  // out_angle_three, out_angle_four, out_angle_five, out_steps
  output logic [127:0] out_tdata,
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [wlpc_pkg::GRP_W-1:0] active_group_r;
  logic [wlpc_pkg::GRP_W-1:0] group_sel;
  logic                       reg_sel;
  logic                       cfg_wr;

  wlpc_pkg::wp_t      wp_in;
  wlpc_pkg::wp_t      rd_q;
  wlpc_pkg::mem_req_t req;
  wlpc_pkg::res_t     res;
  logic               idle;
  logic               in_xfer;
  logic               res_take;
  logic               out_tvalid_r;
  logic [127:0]       out_tdata_r;

  // register index is paddr / 4
  assign reg_sel    = (cfg_paddr[2] == 1'b0);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel ? {30'd0, active_group_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_group_r <= '0;
    end else if (cfg_wr && reg_sel) begin
      active_group_r <= cfg_pwdata[wlpc_pkg::GRP_W-1:0];
    end
  end

  // codes 2 and 3 both pick the third list
  assign group_sel = (active_group_r >= 2'd2) ? 2'd2 : active_group_r;

  // unpack the command transfer
  assign wp_in.angle_one   = in_tdata[18:3];
  assign wp_in.angle_two   = in_tdata[34:19];
  assign wp_in.angle_three = in_tdata[50:35];
  assign wp_in.angle_four  = in_tdata[66:51];
  assign wp_in.angle_five  = in_tdata[82:67];
  assign wp_in.steps       = in_tdata[114:83];

  assign in_tready = idle;
  assign in_xfer   = in_tvalid && in_tready;

  wlpc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_xfer),
    .cmd         (in_tdata[2:0]),
    .wp_in       (wp_in),
    .point_index (in_tdata[120:115]),
    .group       (group_sel),
    .res_take    (res_take),
    .rd_q        (rd_q),
    .idle        (idle),
    .req         (req),
    .res         (res)
  );

  wlpc_store u_store (
    .clk  (clk),
    .req  (req),
    .rd_q (rd_q)
  );

  // output register frees the sequencer while the result waits downstream
  assign res_take = res.valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (!out_tvalid_r || out_tready) begin
      out_tvalid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_tdata_r <= {res.data.steps,
                      res.data.angle_five,
                      res.data.angle_four,
                      res.data.angle_three,
                      res.data.angle_two,
                      res.data.angle_one,
                      res.playing,
                      res.play_cursor,
                      res.entry_count,
                      res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[rtl/core/wlpc_checker.sv]
// port-level checks for the waypoint list block, bound to the top level
// depends on wlpc_pkg and waypoint_list_with_play_cursor

module wlpc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one command at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a transfer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:2] <= 7'(wlpc_pkg::MAX_POINTS))
    else $error("entry count above list capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == wlpc_pkg::ST_FULL |->
      out_tdata[8:2] == 7'(wlpc_pkg::MAX_POINTS))
    else $error("full status on a list that is not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == wlpc_pkg::ST_EMPTY |-> out_tdata[8:2] == 7'd0)
    else $error("empty status on a list with entries");

endmodule

bind waypoint_list_with_play_cursor wlpc_checker u_wlpc_checker (.*);
